FILE: hw/rtl/ace_pkg.sv
package ace_pkg;

    localparam int EST_W  = 48;
    localparam int FRAC_W = 16;
    localparam int RT_W   = 32;
    localparam int MUL_W  = 32;
    localparam int THR_W  = 6;
    localparam int WT_W   = 12;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_NA    = 2'd1,
        ST_UNDEF = 2'd2
    } status_t;

    typedef struct packed {
        logic [EST_W-1:0] estimate;
        status_t          status;
    } result_t;

    // k*(k-1) weight of a histogram class
    function automatic logic [WT_W-1:0] pair_weight(input logic [THR_W-1:0] k);
        logic [THR_W-1:0] km1;
        km1 = k - THR_W'(1);
        return WT_W'(k) * WT_W'(km1);
    endfunction

endpackage

FILE: hw/rtl/ace_richness_estimator_top.sv
// front end: accepts an item, then writes its histogram class back before the next
// last item of a sample: a histogram sweep, then a push into the job queue, with
// busy high; an empty sample also sweeps the histogram
// back end: the shared shift-add multiplier and the 48-step divider work on one
// queued sample at a time; a 2-entry job queue decouples it and busy stays high
// while the queue is full
// result strobe done lasts one cycle and cannot be held off
// reset: a clearing pass over the histogram runs before start is taken
module ace_richness_estimator_top import ace_pkg::*; #(
    parameter int HIST_DEPTH  = 64,
    parameter int COUNT_WIDTH = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [THR_W-1:0]  cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [31:0]       abundance,
    input  logic              last_in_sample,
    input  logic              empty_sample,
    output logic              done,
    output logic [EST_W-1:0]  estimate,
    output logic [1:0]        status
);

    localparam int JOB_W = 1 + RT_W + 3 * COUNT_WIDTH + COUNT_WIDTH + 18;

    logic             q_push, q_full, q_pop, q_empty;
    logic [JOB_W-1:0] push_data, pop_data;
    result_t          res;

    ace_front #(
        .HIST_DEPTH  (HIST_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .JOB_W       (JOB_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .abundance      (abundance),
        .last_in_sample (last_in_sample),
        .empty_sample   (empty_sample),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (push_data)
    );

    ace_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    ace_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .JOB_W       (JOB_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .q_pop   (q_pop),
        .done    (done),
        .result  (res)
    );

    assign estimate = res.estimate;
    assign status   = res.status;

endmodule

FILE: hw/rtl/ace_ram.sv
module ace_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/ace_queue.sv
module ace_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ (push && !full);
        rd_ptr_next = rd_ptr_reg ^ (pop && !empty);
        cnt_next    = cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/ace_front.sv
module ace_front import ace_pkg::*; #(
    parameter int HIST_DEPTH  = 64,
    parameter int COUNT_WIDTH = 24,
    parameter int JOB_W       = 1 + RT_W + 3 * COUNT_WIDTH + COUNT_WIDTH + 18
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic [31:0]      abundance,
    input  logic             last_in_sample,
    input  logic             empty_sample,
    input  logic             q_full,
    output logic             q_push,
    output logic [JOB_W-1:0] q_data
);

    localparam int AW  = $clog2(HIST_DEPTH);
    localparam int CTW = $clog2(HIST_DEPTH + 1);
    localparam int CW  = COUNT_WIDTH;
    localparam int TW  = COUNT_WIDTH + 18;
    localparam int PW  = COUNT_WIDTH + WT_W;
    localparam logic [THR_W-1:0] THR_CAP =
        (HIST_DEPTH - 1 > 63) ? THR_W'(63) : THR_W'(HIST_DEPTH - 1);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_UPD   = 4'b0010,
        F_SWEEP = 4'b0100,
        F_PUSH  = 4'b1000
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic [THR_W-1:0] thr_reg;
    logic             sum_mode_reg, sum_mode_next;
    logic [CTW-1:0]   sw_cnt_reg, sw_cnt_next;
    logic             rd_valid_reg;
    logic [AW-1:0]    rd_k_reg;
    logic             prod_valid_reg;
    logic [PW-1:0]    prod_reg;
    logic [AW-1:0]    addr_reg;
    logic             rare_reg;
    logic             last_reg;
    logic [RT_W-1:0]  n_reg, n_next;
    logic [CW-1:0]    sr_reg, sr_next;
    logic [CW-1:0]    sa_reg, sa_next;
    logic [CW-1:0]    f1_reg, f1_next;
    logic [TW-1:0]    t_reg, t_next;

    logic             accept;
    logic [32:0]      ab_sum;
    logic [24:0]      x_val;
    logic [THR_W-1:0] thr_eff;
    logic             is_rare;
    logic             issuing;
    logic             sweep_done;
    logic [RT_W:0]    n_add;
    logic [AW+THR_W-1:0] k_ext;
    logic             use_term;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CW-1:0]    ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [CW-1:0]    ram_rdata;

    ace_ram #(
        .WIDTH (CW),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy    = (state_reg != F_IDLE) || q_full;
    assign accept  = start && !busy;
    assign ab_sum  = {1'b0, abundance} + 33'd255;
    assign x_val   = ab_sum[32:8];
    assign thr_eff = (thr_reg < THR_CAP) ? thr_reg : THR_CAP;
    assign is_rare = (x_val <= 25'(thr_eff));
    assign issuing = (state_reg == F_SWEEP) && (sw_cnt_reg < CTW'(HIST_DEPTH));
    assign sweep_done = (sw_cnt_reg == CTW'(HIST_DEPTH)) && !rd_valid_reg && !prod_valid_reg;
    assign n_add   = {1'b0, n_reg} + (RT_W + 1)'(x_val[THR_W-1:0]);
    assign k_ext   = (AW + THR_W)'(rd_k_reg);
    assign use_term = sum_mode_reg && (k_ext >= (AW + THR_W)'(2))
                      && (k_ext <= (AW + THR_W)'(thr_eff));

    // empty sample sends a bare marker, a finished sample sends its sums
    assign q_push = (accept && empty_sample) || ((state_reg == F_PUSH) && !q_full);
    assign q_data = (state_reg == F_PUSH) ? {1'b0, n_reg, f1_reg, sr_reg, sa_reg, t_reg}
                                          : {1'b1, (JOB_W - 1)'(0)};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_raddr = x_val[AW-1:0];
        if (issuing)
        begin
            ram_we    = 1'b1;
            ram_waddr = sw_cnt_reg[AW-1:0];
            ram_raddr = sw_cnt_reg[AW-1:0];
        end
        else if (state_reg == F_UPD)
        begin
            ram_we    = rare_reg;
            ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + CW'(1);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        sum_mode_next = sum_mode_reg;
        sw_cnt_next   = sw_cnt_reg;
        n_next        = n_reg;
        sr_next       = sr_reg;
        sa_next       = sa_reg;
        f1_next       = f1_reg;
        t_next        = t_reg;

        if (issuing)
        begin
            sw_cnt_next = sw_cnt_reg + CTW'(1);
        end
        if (rd_valid_reg && (rd_k_reg == AW'(1)))
        begin
            f1_next = ram_rdata;
        end
        if (prod_valid_reg)
        begin
            t_next = t_reg + TW'(prod_reg);
        end

        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (empty_sample)
                    begin
                        n_next        = '0;
                        sr_next       = '0;
                        sa_next       = '0;
                        t_next        = '0;
                        sum_mode_next = 1'b0;
                        sw_cnt_next   = '0;
                        state_next    = F_SWEEP;
                    end
                    else
                    begin
                        if (is_rare)
                        begin
                            n_next  = n_add[RT_W] ? '1 : n_add[RT_W-1:0];
                            sr_next = (sr_reg == '1) ? sr_reg : sr_reg + CW'(1);
                        end
                        else
                        begin
                            sa_next = (sa_reg == '1) ? sa_reg : sa_reg + CW'(1);
                        end
                        state_next = F_UPD;
                    end
                end
            end
            F_UPD:
            begin
                if (last_reg)
                begin
                    sum_mode_next = 1'b1;
                    sw_cnt_next   = '0;
                    t_next        = '0;
                    state_next    = F_SWEEP;
                end
                else
                begin
                    state_next = F_IDLE;
                end
            end
            F_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = sum_mode_reg ? F_PUSH : F_IDLE;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    n_next     = '0;
                    sr_next    = '0;
                    sa_next    = '0;
                    t_next     = '0;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_SWEEP;
            thr_reg        <= THR_W'(10);
            sum_mode_reg   <= 1'b0;
            sw_cnt_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            n_reg          <= '0;
            sr_reg         <= '0;
            sa_reg         <= '0;
            f1_reg         <= '0;
            t_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            sum_mode_reg   <= sum_mode_next;
            sw_cnt_reg     <= sw_cnt_next;
            rd_valid_reg   <= issuing;
            prod_valid_reg <= rd_valid_reg && use_term;
            n_reg          <= n_next;
            sr_reg         <= sr_next;
            sa_reg         <= sa_next;
            f1_reg         <= f1_next;
            t_reg          <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_k_reg <= sw_cnt_reg[AW-1:0];
        prod_reg <= PW'(pair_weight(k_ext[THR_W-1:0])) * PW'(ram_rdata);
        if (accept)
        begin
            addr_reg <= x_val[AW-1:0];
            rare_reg <= is_rare;
            last_reg <= last_in_sample;
        end
    end

endmodule

FILE: hw/rtl/ace_back.sv
module ace_back import ace_pkg::*; #(
    parameter int COUNT_WIDTH = 24,
    parameter int JOB_W       = 1 + RT_W + 3 * COUNT_WIDTH + COUNT_WIDTH + 18
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  logic [JOB_W-1:0] q_data,
    output logic             q_pop,
    output logic             done,
    output result_t          result
);

    localparam int CW = COUNT_WIDTH;
    localparam int TW = COUNT_WIDTH + 18;
    localparam int PW = (3 * CW + 51 > CW + 97) ? 3 * CW + 51 : CW + 97;
    localparam int RW = (PW + 18 > 146) ? PW + 18 : 146;

    typedef enum logic [7:0] {
        B_IDLE  = 8'b00000001,
        B_CHECK = 8'b00000010,
        B_LOAD  = 8'b00000100,
        B_MUL   = 8'b00001000,
        B_STORE = 8'b00010000,
        B_PREP  = 8'b00100000,
        B_DIV   = 8'b01000000,
        B_FIN   = 8'b10000000
    } bstate_t;

    typedef enum logic [3:0] {
        OP_SRT = 4'd0,
        OP_DE  = 4'd1,
        OP_GF1 = 4'd2,
        OP_GN  = 4'd3,
        OP_SRN = 4'd4,
        OP_SND = 4'd5,
        OP_SNE = 4'd6,
        OP_DD  = 4'd7,
        OP_DDE = 4'd8
    } op_t;

    bstate_t          state_reg, state_next;
    op_t              op_reg, op_next;
    logic             mt_reg;
    logic [RT_W-1:0]  n_reg;
    logic [CW-1:0]    f1_reg, sr_reg, sa_reg;
    logic [TW-1:0]    t_reg;
    logic [RT_W-1:0]  d_reg, e_reg;
    logic [RW-1:0]    x_reg, y_reg, acc_reg, a_reg, rem_reg, dv_reg;
    logic [MUL_W-1:0] m_reg;
    logic [EST_W-1:0] q_reg;
    logic [5:0]       cnt_reg;
    logic             done_reg;
    result_t          res_reg;

    logic [RW-1:0]    op_a;
    logic [MUL_W-1:0] op_m;
    logic [RW-1:0]    rem_init;
    logic [EST_W:0]   est_sum;

    assign q_pop  = (state_reg == B_IDLE) && !q_empty;
    assign done   = done_reg;
    assign result = res_reg;
    assign rem_init = (x_reg << 17) + y_reg;
    assign est_sum  = {1'b0, q_reg} + (EST_W + 1)'({sa_reg, FRAC_W'(0)});

    always_comb
    begin
        op_a = y_reg;
        op_m = e_reg;
        case (op_reg)
            OP_SRT:  begin op_a = RW'(t_reg);  op_m = MUL_W'(sr_reg); end
            OP_DE:   begin op_a = RW'(d_reg);  op_m = e_reg;          end
            OP_GF1:  begin op_a = x_reg;       op_m = MUL_W'(f1_reg); end
            OP_GN:   begin op_a = x_reg;       op_m = n_reg;          end
            OP_SRN:  begin op_a = RW'(sr_reg); op_m = n_reg;          end
            OP_SND:  begin op_a = y_reg;       op_m = d_reg;          end
            OP_SNE:  begin op_a = y_reg;       op_m = e_reg;          end
            OP_DD:   begin op_a = RW'(d_reg);  op_m = d_reg;          end
            default: begin op_a = y_reg;       op_m = e_reg;          end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            B_IDLE:  state_next = q_empty ? B_IDLE : B_CHECK;
            B_CHECK:
            begin
                if (mt_reg || (n_reg < RT_W'(2)) || (RT_W'(f1_reg) >= n_reg))
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    op_next    = OP_SRT;
                    state_next = B_LOAD;
                end
            end
            B_LOAD:  state_next = B_MUL;
            B_MUL:   state_next = (m_reg == '0) ? B_STORE : B_MUL;
            B_STORE:
            begin
                op_next    = op_t'(op_reg + 4'd1);
                state_next = (op_reg == OP_DDE) ? B_PREP : B_LOAD;
            end
            B_PREP:  state_next = (rem_init >= (y_reg << 49)) ? B_IDLE : B_DIV;
            B_DIV:   state_next = (cnt_reg == 6'(EST_W - 1)) ? B_FIN : B_DIV;
            B_FIN:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            op_reg    <= OP_SRT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            done_reg  <= ((state_reg == B_CHECK) && (state_next == B_IDLE))
                         || ((state_reg == B_PREP) && (state_next == B_IDLE))
                         || (state_reg == B_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                {mt_reg, n_reg, f1_reg, sr_reg, sa_reg, t_reg} <= q_data;
            end
            B_CHECK:
            begin
                d_reg <= n_reg - RT_W'(f1_reg);
                e_reg <= n_reg - RT_W'(1);
                res_reg.estimate <= '0;
                res_reg.status   <= mt_reg ? ST_NA : ST_UNDEF;
            end
            B_LOAD:
            begin
                acc_reg <= '0;
                a_reg   <= op_a;
                m_reg   <= op_m;
            end
            B_MUL:
            begin
                // shift-add, stops once the multiplier runs out of ones
                if (m_reg[0])
                begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg <= a_reg << 1;
                m_reg <= m_reg >> 1;
            end
            B_STORE:
            begin
                case (op_reg)
                    OP_SRT, OP_GF1, OP_GN: x_reg <= acc_reg;
                    OP_DE:   x_reg <= (x_reg > acc_reg) ? x_reg - acc_reg : '0;
                    OP_SNE:  x_reg <= x_reg + acc_reg;
                    default: y_reg <= acc_reg;
                endcase
            end
            B_PREP:
            begin
                rem_reg <= rem_init;
                dv_reg  <= y_reg << 48;
                cnt_reg <= '0;
                q_reg   <= '0;
                res_reg.estimate <= '1;
                res_reg.status   <= ST_VALID;
            end
            B_DIV:
            begin
                if (rem_reg >= dv_reg)
                begin
                    rem_reg <= rem_reg - dv_reg;
                end
                q_reg   <= {q_reg[EST_W-2:0], rem_reg >= dv_reg};
                dv_reg  <= dv_reg >> 1;
                cnt_reg <= cnt_reg + 6'd1;
            end
            B_FIN:
            begin
                res_reg.estimate <= est_sum[EST_W] ? '1 : est_sum[EST_W-1:0];
                res_reg.status   <= ST_VALID;
            end
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
    end

endmodule

FILE: hw/rtl/ace_checker.sv
module ace_checker import ace_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic [EST_W-1:0] estimate,
    input logic [1:0]       status
);

    // every transaction keeps the front busy right after acceptance, for the write-back or the sweep
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low right after an accepted transaction");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_UNDEF)
        else $error("reserved status code on result");

    a_zero_estimate: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_VALID |-> estimate == '0)
        else $error("nonzero estimate with non-valid status");

endmodule

bind ace_richness_estimator_top ace_checker u_ace_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .estimate (estimate),
    .status   (status)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ace_pkg::*;

    localparam int HDEPTH    = 64;
    localparam int CWIDTH    = 24;
    localparam int SETTLE    = 500;
    localparam int MAX_CYCLE = 2000000;

    typedef struct {
        logic [EST_W-1:0] estimate;
        status_t          status;
    } ace_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [THR_W-1:0]  cfg_wdata;
    logic              start;
    logic              busy;
    logic [31:0]       abundance;
    logic              last_in_sample;
    logic              empty_sample;
    logic              done;
    logic [EST_W-1:0]  estimate;
    logic [1:0]        status;

    ace_richness_estimator_top #(.HIST_DEPTH(HDEPTH), .COUNT_WIDTH(CWIDTH)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .abundance(abundance),
        .last_in_sample(last_in_sample), .empty_sample(empty_sample),
        .done(done), .estimate(estimate), .status(status)
    );

    // predictor state
    logic [THR_W-1:0]  rare_limit;
    logic [CWIDTH-1:0] class_count [HDEPTH];
    logic [31:0]       rare_mass;
    logic [CWIDTH-1:0] rare_count;
    logic [CWIDTH-1:0] abundant_count;

    ace_result_t pending_estimates[$];
    int          fail_count;
    int          item_count;
    int          result_count;
    int          cycle_count;
    bit          no_idle;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [CWIDTH-1:0] bump(input logic [CWIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic clear_sample();
        for (int k = 0; k < HDEPTH; k++)
            class_count[k] = '0;
        rare_mass      = '0;
        rare_count     = '0;
        abundant_count = '0;
    endtask

    function automatic ace_result_t ace_estimate();
        ace_result_t r;
        logic [255:0] n, f1, sr, d, e, t, num, tmp, den, q;
        r.estimate = '0;
        r.status   = ST_VALID;
        n  = 256'(rare_mass);
        f1 = 256'(class_count[1]);
        sr = 256'(rare_count);
        if (n < 2 || f1 >= n)
        begin
            r.status = ST_UNDEF;
            return r;
        end
        d = n - f1;
        e = n - 1;
        t = '0;
        for (int k = 2; k <= rare_limit; k++)
            t = t + 256'(k) * 256'(k - 1) * 256'(class_count[k]);
        num = t * sr;
        tmp = d * e;
        num = (num > tmp) ? num - tmp : '0;
        num = num * f1 * n + sr * n * d * e;
        den = d * d * e;
        q = ((num << 17) + den) / (den << 1);
        if (q >= (256'(1) << EST_W))
            r.estimate = '1;
        else
        begin
            q = q + (256'(abundant_count) << FRAC_W);
            r.estimate = (q >= (256'(1) << EST_W)) ? '1 : q[EST_W-1:0];
        end
        return r;
    endfunction

    task automatic predict(input logic [31:0] ab, input logic last, input logic empty);
        logic [32:0] x;
        if (empty)
        begin
            clear_sample();
            pending_estimates.push_back('{estimate: '0, status: ST_NA});
            return;
        end
        x = (33'(ab) + 33'd255) >> 8;
        if (x <= 33'(rare_limit))
        begin
            rare_mass  = (rare_mass > 32'hFFFF_FFFF - x[31:0]) ? 32'hFFFF_FFFF
                                                               : rare_mass + x[31:0];
            rare_count = bump(rare_count);
            class_count[x[5:0]] = bump(class_count[x[5:0]]);
        end
        else
            abundant_count = bump(abundant_count);
        if (last)
        begin
            pending_estimates.push_back(ace_estimate());
            clear_sample();
        end
    endtask

    function automatic int idle_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a rising edge; returns at the edge of acceptance or after the gap
    task automatic send_item(input logic [31:0] ab, input logic last, input logic empty);
        int gap;
        start          <= 1'b1;
        abundance      <= ab;
        last_in_sample <= last;
        empty_sample   <= empty;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        predict(ab, last, empty);
        item_count++;
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        start <= 1'b0;
        wait (pending_estimates.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        rare_limit  = v;
    endtask

    // done lasts one cycle, so a single look at the falling edge sees it once
    always @(negedge clk)
    begin
        ace_result_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (pending_estimates.size() == 0)
            begin
                $error("unexpected transaction: estimate %0h status %0d", estimate, status);
                fail_count++;
            end
            else
            begin
                want = pending_estimates.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, status);
                    fail_count++;
                end
                if (estimate !== want.estimate)
                begin
                    $error("estimate: expected %0h actual %0h", want.estimate, estimate);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_abundance();
        int x;
        if ($urandom_range(0, 9) < 2)
            return $urandom;
        x = $urandom_range(0, rare_limit + 4);
        if (x == 0)
            return 32'd0;
        return (32'(x) << 8) - 32'($urandom_range(0, 255));
    endfunction

    task automatic test_directed();
        // extremes of the field and rounding at class edges
        send_item(32'd0, 1'b0, 1'b0);
        send_item(32'd1, 1'b0, 1'b0);
        send_item(32'd256, 1'b0, 1'b0);
        send_item(32'd257, 1'b0, 1'b0);
        send_item(32'd2560, 1'b0, 1'b0);
        send_item(32'd2561, 1'b0, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        // empty sample, and empty wins over last
        send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_item(32'd512, 1'b0, 1'b0);
        send_item(32'd512, 1'b1, 1'b1);
        // zero divisor: single singleton, only singletons, only abundant
        send_item(32'd200, 1'b1, 1'b0);
        send_item(32'd256, 1'b0, 1'b0);
        send_item(32'd256, 1'b1, 1'b0);
        send_item(32'd9000, 1'b1, 1'b0);
        // zero abundance only
        send_item(32'd0, 1'b1, 1'b0);
        // doubletons with singletons gives a real estimate
        send_item(32'd512, 1'b0, 1'b0);
        send_item(32'd512, 1'b0, 1'b0);
        send_item(32'd300, 1'b0, 1'b0);
        send_item(32'd256, 1'b0, 1'b0);
        send_item(32'd100000, 1'b1, 1'b0);
    endtask

    task automatic run_sample();
        int len;
        int r;
        len = $urandom_range(1, 14);
        for (int i = 0; i < len - 1; i++)
            send_item(pick_abundance(), 1'b0, $urandom_range(0, 99) == 0);
        r = $urandom_range(0, 19);
        send_item(pick_abundance(), 1'b1, r == 0);
    endtask

    task automatic test_thresholds();
        logic [THR_W-1:0] lims[4] = '{6'd0, 6'd1, 6'd63, 6'd2};
        foreach (lims[i])
        begin
            write_threshold(lims[i]);
            repeat (6) run_sample();
        end
    endtask

    task automatic test_random();
        while (item_count < 1550)
        begin
            if (item_count % 300 < 5)
                write_threshold(THR_W'($urandom_range(1, 63)));
            no_idle = ($urandom_range(0, 7) == 0);
            run_sample();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        start          = 1'b0;
        abundance      = '0;
        last_in_sample = 1'b0;
        empty_sample   = 1'b0;
        fail_count     = 0;
        item_count     = 0;
        result_count   = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        rare_limit     = 6'd10;
        clear_sample();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_thresholds();
        write_threshold(6'd10);
        test_random();

        start <= 1'b0;
        wait (pending_estimates.size() == 0);
        repeat (SETTLE) @(posedge clk);
        $display("fed %0d abundances and checked %0d estimates", item_count, result_count);
        $display("thresholds 0, 1, 2, 10, 63 and random ones, empty and undefined samples");
        if (fail_count == 0 && pending_estimates.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
